// ===== src/dpfs_pkg.sv =====
// Package for the delimited price field summer.
// Byte codes, register indexes, reset values and the result record type.
// No dependencies.
package dpfs_pkg;

  localparam int COUNT_BITS_DEFAULT = 48;
  localparam int COUNT_OUT_BITS     = 48;
  localparam int AMOUNT_BITS        = 64;

  // Byte codes
  localparam logic [7:0] LF_BYTE    = 8'd10;
  localparam logic [7:0] CR_BYTE    = 8'd13;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] DIGIT_NINE = 8'd57;
  localparam logic [7:0] FIELD_SAT  = 8'd255;

  // Configuration register indexes
  localparam logic [1:0] REG_SEPARATOR    = 2'd0;
  localparam logic [1:0] REG_DECIMAL_MARK = 2'd1;
  localparam logic [1:0] REG_TARGET_FIELD = 2'd2;

  // Register reset values
  localparam logic [7:0] SEPARATOR_RESET    = 8'd124;
  localparam logic [7:0] DECIMAL_MARK_RESET = 8'd44;
  localparam logic [7:0] TARGET_FIELD_RESET = 8'd10;

  typedef struct packed {
    logic [AMOUNT_BITS-1:0]    total_sales;
    logic [COUNT_OUT_BITS-1:0] transaction_count;
    logic [COUNT_OUT_BITS-1:0] record_count;
    logic [AMOUNT_BITS-1:0]    held_amount;
    logic                      final_result;
  } result_t;

endpackage

// ===== src/delimited_price_field_summer.sv =====
// Top level of the delimited price field summer: byte parser, totals and
// a two-slot result buffer. Depends on dpfs_pkg.
//
// Delimited price field summer. Takes one text byte per request and parses
// separator-delimited records: it counts separators to find the target
// field, builds the integer part of the price from its decimal digits up to
// the decimal mark, and at each CR or LF (each one counts as a record end)
// closes the open transaction when a price was read that differs from the
// held amount. A request flagged stream_end does the same final check and
// clears the record parse state, keeping the held amount unless the byte is
// also a line end that closes a transaction. Every line-end or stream_end
// byte gives one result request; other bytes give none. Rate: one byte per
// clock cycle while in_stall is low. The parse state is updated as a byte is
// accepted, by one pass of compare / multiply-by-ten-and-add logic. Results
// go to an output register backed by a one-entry skid register; in_stall
// rises only when that skid entry is full, i.e. when two results are waiting.
// Configuration writes take effect at the next edge and are meant to be
// issued while the block is idle.
module delimited_price_field_summer #(
  parameter int COUNT_BITS = dpfs_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_write_en,
  input  logic [1:0]                            cfg_index,
  input  logic [7:0]                            cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            text_byte,
  input  logic                                  stream_end,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dpfs_pkg::AMOUNT_BITS-1:0]      total_sales,
  output logic [dpfs_pkg::COUNT_OUT_BITS-1:0]   transaction_count,
  output logic [dpfs_pkg::COUNT_OUT_BITS-1:0]   record_count,
  output logic [dpfs_pkg::AMOUNT_BITS-1:0]      held_amount,
  output logic                                  final_result
);

  localparam int AB = dpfs_pkg::AMOUNT_BITS;

  // configuration registers
  logic [7:0] separator_char;
  logic [7:0] decimal_mark;
  logic [7:0] target_field;

  // parse and total state
  logic [7:0]            field_counter,     field_counter_next;
  logic [AB-1:0]         price_accumulator, price_accumulator_next;
  logic                  price_seen,        price_seen_next;
  logic [AB-1:0]         open_amount,       open_amount_next;
  logic [AB-1:0]         sales_sum,         sales_sum_next;
  logic [COUNT_BITS-1:0] transactions,      transactions_next;
  logic [COUNT_BITS-1:0] records,           records_next;

  // result buffer
  logic               out_valid_q;
  dpfs_pkg::result_t  out_data;
  logic               skid_valid;
  dpfs_pkg::result_t  skid_data;
  dpfs_pkg::result_t  result_next;

  logic in_accept;
  logic out_fire;
  logic emit;

  // byte classification
  logic          is_sep, is_nl, in_field, is_digit, digit_upd, mark_upd, do_close;
  logic [AB-1:0] acc_mid, check_acc;
  logic          seen_mid, check_seen;
  logic [7:0]    field_bumped;
  logic [63:0]   trans_wide, records_wide;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_fire  = out_valid_q && !out_stall;

  // Configuration writes; index 3 is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= dpfs_pkg::SEPARATOR_RESET;
      decimal_mark   <= dpfs_pkg::DECIMAL_MARK_RESET;
      target_field   <= dpfs_pkg::TARGET_FIELD_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        dpfs_pkg::REG_SEPARATOR:    separator_char <= cfg_data;
        dpfs_pkg::REG_DECIMAL_MARK: decimal_mark   <= cfg_data;
        dpfs_pkg::REG_TARGET_FIELD: target_field   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-byte update. Test order: separator, line end, then digit / mark
  // inside the target field only.
  always_comb begin
    is_sep   = (text_byte == separator_char);
    is_nl    = !is_sep && ((text_byte == dpfs_pkg::LF_BYTE) ||
                           (text_byte == dpfs_pkg::CR_BYTE));
    in_field = !is_sep && !is_nl && (field_counter == target_field) &&
               (field_counter != dpfs_pkg::FIELD_SAT);
    is_digit = (text_byte >= dpfs_pkg::DIGIT_ZERO) &&
               (text_byte <= dpfs_pkg::DIGIT_NINE);
    digit_upd = in_field && is_digit;
    // the decimal mark only counts once a digit has been read
    mark_upd  = in_field && !is_digit && (text_byte == decimal_mark) && price_seen;

    // acc * 10 + digit, wrapping at 64 bits
    acc_mid  = digit_upd ? ((price_accumulator << 3) + (price_accumulator << 1) +
                            AB'(8'(text_byte - dpfs_pkg::DIGIT_ZERO)))
                         : price_accumulator;
    seen_mid = price_seen || digit_upd;

    // line end checks the price before this byte; stream end checks after it
    check_acc  = is_nl ? price_accumulator : acc_mid;
    check_seen = is_nl ? price_seen : seen_mid;
    do_close   = (is_nl || stream_end) && check_seen && (check_acc != open_amount);

    field_bumped = (field_counter == dpfs_pkg::FIELD_SAT) ? field_counter
                                                          : field_counter + 8'd1;

    sales_sum_next    = do_close ? sales_sum + open_amount : sales_sum;
    transactions_next = do_close ? transactions + COUNT_BITS'(1) : transactions;
    // stream end on a plain byte keeps the held amount
    open_amount_next  = (do_close && is_nl) ? price_accumulator : open_amount;
    records_next      = is_nl ? records + COUNT_BITS'(1) : records;

    if (is_nl || stream_end) begin
      field_counter_next     = 8'd0;
      price_accumulator_next = '0;
      price_seen_next        = 1'b0;
    end else begin
      field_counter_next     = (is_sep || mark_upd) ? field_bumped : field_counter;
      price_accumulator_next = acc_mid;
      price_seen_next        = seen_mid;
    end

    emit = is_nl || stream_end;

    trans_wide   = 64'(transactions_next);
    records_wide = 64'(records_next);
    result_next.total_sales       = sales_sum_next;
    result_next.transaction_count = trans_wide[dpfs_pkg::COUNT_OUT_BITS-1:0];
    result_next.record_count      = records_wide[dpfs_pkg::COUNT_OUT_BITS-1:0];
    result_next.held_amount       = open_amount_next;
    result_next.final_result      = stream_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_counter     <= 8'd0;
      price_accumulator <= '0;
      price_seen        <= 1'b0;
      open_amount       <= '0;
      sales_sum         <= '0;
      transactions      <= '0;
      records           <= '0;
    end else if (in_accept) begin
      field_counter     <= field_counter_next;
      price_accumulator <= price_accumulator_next;
      price_seen        <= price_seen_next;
      open_amount       <= open_amount_next;
      sales_sum         <= sales_sum_next;
      transactions      <= transactions_next;
      records           <= records_next;
    end
  end

  // Result buffer: output register plus one skid entry. New requests are
  // refused while the skid entry holds a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      if (!out_valid_q || out_fire) begin
        if (skid_valid) begin
          out_valid_q <= 1'b1;
          skid_valid  <= 1'b0;
        end else begin
          out_valid_q <= in_accept && emit;
        end
      end else if (in_accept && emit) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_accept && emit) begin
        out_data <= result_next;
      end
    end else if (in_accept && emit) begin
      skid_data <= result_next;
    end
  end

  assign out_valid         = out_valid_q;
  assign total_sales       = out_data.total_sales;
  assign transaction_count = out_data.transaction_count;
  assign record_count      = out_data.record_count;
  assign held_amount       = out_data.held_amount;
  assign final_result      = out_data.final_result;

`ifndef ASSERT_OFF
  // skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // a drained skid entry moves up into the output register
  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (out_valid_q && !skid_valid))
    else $error("skid entry not forwarded");

  // each accepted line end counts exactly one record
  a_record_step: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_nl) |=> (records == $past(records) + COUNT_BITS'(1)))
    else $error("record count did not advance on line end");

  // stream end leaves a clean record parse state
  a_stream_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && stream_end) |=> (field_counter == 8'd0 && !price_seen &&
                                   price_accumulator == '0))
    else $error("parse state not cleared after stream end");

  // totals move only on accepted requests
  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> ($stable(sales_sum) && $stable(transactions)))
    else $error("totals changed without a request");
`endif

endmodule
